// File: rtl/core/assert_macros.svh
// assertion macros for the cache rtl, included by lbc_ctrl
// expects aclk and aresetn in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define LBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// expression must never be true out of reset
`define LBC_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

// File: rtl/core/lbc_pkg.sv
// lbc_pkg: sizes, command codes and request/response types of the block cache
// used by every module of the cache; depends on nothing
package lbc_pkg;

    localparam int ENTRIES    = 8;
    localparam int BLOCK_BITS = 32;
    localparam int DATA_BITS  = 32;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int CFG_W      = 4;
    localparam int LIM_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int STAT_W     = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(8);

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DIRTY  = 2'd2;

    localparam logic REG_MAX_ENTRIES = 1'b0;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [BLOCK_BITS-1:0] block_number;
        logic [DATA_BITS-1:0]  data_in;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic [DATA_BITS-1:0]  data_out;
        logic                  evicted;
        logic [BLOCK_BITS-1:0] evicted_block;
        logic                  evicted_dirty;
        logic [STAT_W-1:0]     hit_count;
        logic [STAT_W-1:0]     miss_count;
    } rsp_t;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] block;
        logic [DATA_BITS-1:0]  data;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
        entry_t           wdata;
    } mem_req_t;

endpackage

// File: rtl/core/lbc_cfg.sv
// lbc_cfg: apb register block holding the max_entries limit
// depends on lbc_pkg
module lbc_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lbc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lbc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lbc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [lbc_pkg::CFG_W-1:0]        max_entries
);
    import lbc_pkg::*;

    logic [CFG_W-1:0] max_entries_reg;
    logic             sel_max;

    assign sel_max     = (paddr[APB_ADDR_W-1] == REG_MAX_ENTRIES);
    assign pready      = 1'b1;
    assign max_entries = max_entries_reg;
    assign prdata      = sel_max ? APB_DATA_W'(max_entries_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAX_ENTRIES_RST;
        end else if (psel && penable && pwrite && pready && sel_max) begin
            max_entries_reg <= pwdata[CFG_W-1:0];
        end
    end

endmodule

// File: rtl/core/lbc_store.sv
// lbc_store: block number and data word memory, one port, registered read
// depends on lbc_pkg
module lbc_store (
    input  logic               aclk,
    input  lbc_pkg::mem_req_t  mem_req,
    output lbc_pkg::entry_t    rd_entry
);
    import lbc_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rd_q;

    assign rd_entry = rd_q;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.addr] <= mem_req.wdata;
        end
        if (mem_req.rd_en) begin
            rd_q <= mem[mem_req.addr];
        end
    end

endmodule

// File: rtl/core/lbc_ctrl.sv
// lbc_ctrl: request sequencer, entry recency/valid/dirty state, counters, result register
// depends on lbc_pkg, lbc_store (through mem_req/rd_entry) and assert_macros.svh
module lbc_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lbc_pkg::CFG_W-1:0]   max_entries,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lbc_pkg::req_t               s_req,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lbc_pkg::rsp_t               m_rsp,
    output lbc_pkg::mem_req_t           mem_req,
    input  lbc_pkg::entry_t             rd_entry
);
    import lbc_pkg::*;
    `include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_APPLY  = 3'd2;
    localparam logic [2:0] ST_EVICT  = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]            state_reg,    state_next;
    req_t                  req_reg,      req_next;
    logic [CNT_W-1:0]      iss_reg,      iss_next;
    logic                  cmp_vld_reg,  cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg,  cmp_idx_next;
    logic                  found_reg,    found_next;
    logic [IDX_W-1:0]      hit_idx_reg,  hit_idx_next;
    logic [DATA_BITS-1:0]  hit_data_reg, hit_data_next;
    logic [IDX_W-1:0]      vic_idx_reg,  vic_idx_next;
    logic                  free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  ev_reg,       ev_next;
    logic [BLOCK_BITS-1:0] ev_blk_reg,   ev_blk_next;
    logic                  ev_dirty_reg, ev_dirty_next;
    logic [ENTRIES-1:0]    valid_reg,    valid_next;
    logic [ENTRIES-1:0]    dirty_reg,    dirty_next;
    logic [IDX_W-1:0]      rank_reg  [ENTRIES];
    logic [IDX_W-1:0]      rank_next [ENTRIES];
    logic [CNT_W-1:0]      used_reg,     used_next;
    logic [STAT_W-1:0]     hits_reg,     hits_next;
    logic [STAT_W-1:0]     misses_reg,   misses_next;
    rsp_t                  rsp_reg,      rsp_next;
    logic                  m_valid_reg,  m_valid_next;

    logic [LIM_W-1:0]      limit;
    logic                  cmp_hit_vld;
    logic                  cmp_match;
    logic [IDX_W-1:0]      touch_rank;
    logic                  lookup_hit;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    always_comb begin
        priority if (max_entries == '0) begin
            limit = LIM_W'(1);
        end else if (LIM_W'(max_entries) > LIM_W'(ENTRIES)) begin
            limit = LIM_W'(ENTRIES);
        end else begin
            limit = LIM_W'(max_entries);
        end
    end

    assign cmp_hit_vld = valid_reg[cmp_idx_reg];
    assign cmp_match   = cmp_vld_reg && cmp_hit_vld
                         && (rd_entry.block == req_reg.block_number);
    assign touch_rank  = rank_reg[hit_idx_reg];
    assign lookup_hit  = (req_reg.cmd == CMD_LOOKUP) && found_reg;

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        iss_next      = iss_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        found_next    = found_reg;
        hit_idx_next  = hit_idx_reg;
        hit_data_next = hit_data_reg;
        vic_idx_next  = vic_idx_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        ev_next       = ev_reg;
        ev_blk_next   = ev_blk_reg;
        ev_dirty_next = ev_dirty_reg;
        valid_next    = valid_reg;
        dirty_next    = dirty_reg;
        rank_next     = rank_reg;
        used_next     = used_reg;
        hits_next     = hits_reg;
        misses_next   = misses_reg;
        rsp_next      = rsp_reg;
        m_valid_next  = m_valid_reg;
        mem_req       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_req;
                    iss_next      = '0;
                    cmp_vld_next  = 1'b0;
                    found_next    = 1'b0;
                    free_vld_next = 1'b0;
                    ev_next       = 1'b0;
                    ev_dirty_next = 1'b0;
                    state_next    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // one read issued and one tag compared per cycle
                if (iss_reg < CNT_W'(ENTRIES)) begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = iss_reg[IDX_W-1:0];
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = iss_reg[IDX_W-1:0];
                    iss_next      = iss_reg + CNT_W'(1);
                end else begin
                    cmp_vld_next = 1'b0;
                end
                if (cmp_vld_reg) begin
                    if (cmp_hit_vld
                        && (CNT_W'(rank_reg[cmp_idx_reg]) == used_reg - CNT_W'(1))) begin
                        vic_idx_next = cmp_idx_reg;
                    end
                    if (!cmp_hit_vld && !free_vld_reg) begin
                        free_vld_next = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                    if (cmp_match) begin
                        found_next    = 1'b1;
                        hit_idx_next  = cmp_idx_reg;
                        hit_data_next = rd_entry.data;
                        cmp_vld_next  = 1'b0;
                        state_next    = ST_APPLY;
                    end else if (cmp_idx_reg == IDX_W'(ENTRIES - 1)) begin
                        cmp_vld_next = 1'b0;
                        state_next   = ST_APPLY;
                    end
                end
            end
            ST_APPLY: begin
                state_next = ST_OUT;
                unique case (req_reg.cmd)
                    CMD_LOOKUP: begin
                        if (found_reg) begin
                            // move hit entry to most recent
                            for (int i = 0; i < ENTRIES; i++) begin
                                if (valid_reg[i] && (IDX_W'(i) != hit_idx_reg)
                                    && (rank_reg[i] < touch_rank)) begin
                                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                                end
                            end
                            rank_next[hit_idx_reg] = '0;
                            if (hits_reg != '1) begin
                                hits_next = hits_reg + STAT_W'(1);
                            end
                        end else if (misses_reg != '1) begin
                            misses_next = misses_reg + STAT_W'(1);
                        end
                    end
                    CMD_INSERT: begin
                        if (!found_reg) begin
                            if (LIM_W'(used_reg) >= limit) begin
                                mem_req.rd_en = 1'b1;
                                mem_req.addr  = vic_idx_reg;
                                state_next    = ST_EVICT;
                            end else begin
                                state_next = ST_FILL;
                            end
                        end
                    end
                    CMD_DIRTY: begin
                        if (found_reg) begin
                            dirty_next[hit_idx_reg] = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_EVICT: begin
                ev_next                  = 1'b1;
                ev_blk_next              = rd_entry.block;
                ev_dirty_next            = dirty_reg[vic_idx_reg];
                valid_next[vic_idx_reg]  = 1'b0;
                dirty_next[vic_idx_reg]  = 1'b0;
                rank_next[vic_idx_reg]   = '0;
                used_next                = used_reg - CNT_W'(1);
                // lowest free slot after the victim leaves
                if (!free_vld_reg || (vic_idx_reg < free_idx_reg)) begin
                    free_vld_next = 1'b1;
                    free_idx_next = vic_idx_reg;
                end
                state_next = ST_FILL;
            end
            ST_FILL: begin
                mem_req.wr_en        = 1'b1;
                mem_req.addr         = free_idx_reg;
                mem_req.wdata.block  = req_reg.block_number;
                mem_req.wdata.data   = req_reg.data_in;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                valid_next[free_idx_reg] = 1'b1;
                dirty_next[free_idx_reg] = 1'b0;
                rank_next[free_idx_reg]  = '0;
                used_next                = used_reg + CNT_W'(1);
                state_next               = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    rsp_next.hit           = lookup_hit;
                    rsp_next.data_out      = lookup_hit ? hit_data_reg : '0;
                    rsp_next.evicted       = ev_reg;
                    rsp_next.evicted_block = ev_reg ? ev_blk_reg : '0;
                    rsp_next.evicted_dirty = ev_reg && ev_dirty_reg;
                    rsp_next.hit_count     = hits_reg;
                    rsp_next.miss_count    = misses_reg;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            valid_reg   <= '0;
            dirty_reg   <= '0;
            used_reg    <= '0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            valid_reg   <= valid_next;
            dirty_reg   <= dirty_next;
            used_reg    <= used_next;
            hits_reg    <= hits_next;
            misses_reg  <= misses_next;
            m_valid_reg <= m_valid_next;
            rank_reg    <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        iss_reg      <= iss_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        hit_idx_reg  <= hit_idx_next;
        hit_data_reg <= hit_data_next;
        vic_idx_reg  <= vic_idx_next;
        free_vld_reg <= free_vld_next;
        free_idx_reg <= free_idx_next;
        ev_reg       <= ev_next;
        ev_blk_reg   <= ev_blk_next;
        ev_dirty_reg <= ev_dirty_next;
        rsp_reg      <= rsp_next;
    end

    `LBC_ASSERT(a_used_matches_valid, $countones(valid_reg) == used_reg, "used count off")
    `LBC_ASSERT(a_fill_slot_free, (state_reg == ST_FILL) |-> (free_vld_reg && !valid_reg[free_idx_reg]), "fill into busy slot")
    `LBC_NEVER(a_hit_and_evict, m_valid_reg && rsp_reg.hit && rsp_reg.evicted, "hit with eviction")
    `LBC_ASSERT(a_single_request, (s_valid && s_ready) |=> !s_ready, "second request taken")

endmodule

// File: rtl/core/lru_block_cache.sv
// sequence: accept in idle; a tag walk reads one memory entry per cycle and ends at a tag match or the
// last entry; then an apply step, for an insert miss an evict step when full and a fill step, then output
// a new request is taken only after the last result is registered, since s_ready is high only in idle;
// a result held by m_ready low stalls the next request in the output step
// reset: synchronous active-low aresetn clears entry state, counters and max_entries to 8
// depends on lbc_pkg, lbc_cfg, lbc_store, lbc_ctrl
module lru_block_cache (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lbc_pkg::req_t                    s_req,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lbc_pkg::rsp_t                    m_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lbc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lbc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lbc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import lbc_pkg::*;

    logic [CFG_W-1:0] max_entries;
    mem_req_t         mem_req;
    entry_t           rd_entry;

    lbc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_entries (max_entries)
    );

    lbc_store u_store (
        .aclk     (aclk),
        .mem_req  (mem_req),
        .rd_entry (rd_entry)
    );

    lbc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .max_entries (max_entries),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rsp       (m_rsp),
        .mem_req     (mem_req),
        .rd_entry    (rd_entry)
    );

endmodule
